// ===== design/bor_pkg.sv =====
package bor_pkg;

    localparam int COORD_BITS = 12;
    localparam int FRAC_BITS  = 16;
    localparam int AREA_BITS  = 2 * COORD_BITS;
    localparam int UNI_BITS   = AREA_BITS + 1;
    localparam int REM_BITS   = AREA_BITS + 2;
    localparam int RATIO_BITS = FRAC_BITS + 1;
    localparam int DIV_STAGES = FRAC_BITS + 1;

    typedef struct packed {
        logic [COORD_BITS-1:0] first_left;
        logic [COORD_BITS-1:0] first_top;
        logic [COORD_BITS-1:0] first_width;
        logic [COORD_BITS-1:0] first_height;
        logic [COORD_BITS-1:0] second_left;
        logic [COORD_BITS-1:0] second_top;
        logic [COORD_BITS-1:0] second_width;
        logic [COORD_BITS-1:0] second_height;
    } in_t;

    typedef struct packed {
        logic [RATIO_BITS-1:0] ratio_q16;
        logic                  overlaps;
    } out_t;

    // Handoff from the area pipeline to the divider.
    typedef struct packed {
        logic                 overlaps;
        logic [AREA_BITS-1:0] inter;
        logic [UNI_BITS-1:0]  uni;
    } area_t;

endpackage

// ===== design/bor_area.sv =====
module bor_area (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           in_valid,
    output logic           in_ready,
    input  bor_pkg::in_t   in_item,
    output logic           out_valid,
    input  logic           out_ready,
    output bor_pkg::area_t out_item
);
    import bor_pkg::*;

    // Stage A: overlap extents
    logic                  a_vld_reg;
    logic                  a_ovl_reg;
    logic [COORD_BITS-1:0] a_ow_reg, a_oh_reg;
    logic [COORD_BITS-1:0] a_w1_reg, a_h1_reg, a_w2_reg, a_h2_reg;
    // Stage B: products
    logic                  b_vld_reg;
    logic                  b_ovl_reg;
    logic [AREA_BITS-1:0]  b_inter_reg, b_a1_reg, b_a2_reg;
    // Stage C: union
    logic                  c_vld_reg;
    area_t                 c_item_reg;

    logic a_rdy, b_rdy, c_rdy;

    logic [COORD_BITS:0]   r1, r2, b1, b2, min_r, min_b;
    logic [COORD_BITS-1:0] max_l, max_t;
    logic [COORD_BITS+1:0] ow_s, oh_s;
    logic                  ovl_next;
    area_t                 c_item_next;
    logic [UNI_BITS-1:0]   uni_sum;

    assign c_rdy    = !c_vld_reg || out_ready;
    assign b_rdy    = !b_vld_reg || c_rdy;
    assign a_rdy    = !a_vld_reg || b_rdy;
    assign in_ready = a_rdy;

    always_comb begin
        r1    = {1'b0, in_item.first_left}  + {1'b0, in_item.first_width};
        r2    = {1'b0, in_item.second_left} + {1'b0, in_item.second_width};
        b1    = {1'b0, in_item.first_top}   + {1'b0, in_item.first_height};
        b2    = {1'b0, in_item.second_top}  + {1'b0, in_item.second_height};
        min_r = (r1 < r2) ? r1 : r2;
        min_b = (b1 < b2) ? b1 : b2;
        max_l = (in_item.first_left > in_item.second_left) ?
                in_item.first_left : in_item.second_left;
        max_t = (in_item.first_top > in_item.second_top) ?
                in_item.first_top : in_item.second_top;
        ow_s  = {1'b0, min_r} - {2'b00, max_l};
        oh_s  = {1'b0, min_b} - {2'b00, max_t};
        // positive when sign clear and nonzero; then it is at most min width
        ovl_next = !ow_s[COORD_BITS+1] && (ow_s != '0) &&
                   !oh_s[COORD_BITS+1] && (oh_s != '0);
    end

    always_comb begin
        uni_sum = UNI_BITS'(b_a1_reg) + UNI_BITS'(b_a2_reg) - UNI_BITS'(b_inter_reg);
        c_item_next.overlaps = b_ovl_reg;
        if (b_ovl_reg) begin
            c_item_next.inter = b_inter_reg;
            c_item_next.uni   = uni_sum;
        end else begin
            // 0 / 1 gives a zero ratio without a special case in the divider
            c_item_next.inter = '0;
            c_item_next.uni   = UNI_BITS'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_vld_reg <= 1'b0;
            b_vld_reg <= 1'b0;
            c_vld_reg <= 1'b0;
        end else begin
            if (a_rdy) a_vld_reg <= in_valid;
            if (b_rdy) b_vld_reg <= a_vld_reg;
            if (c_rdy) c_vld_reg <= b_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (a_rdy) begin
            a_ovl_reg <= ovl_next;
            a_ow_reg  <= ow_s[COORD_BITS-1:0];
            a_oh_reg  <= oh_s[COORD_BITS-1:0];
            a_w1_reg  <= in_item.first_width;
            a_h1_reg  <= in_item.first_height;
            a_w2_reg  <= in_item.second_width;
            a_h2_reg  <= in_item.second_height;
        end
        if (b_rdy) begin
            b_ovl_reg   <= a_ovl_reg;
            b_inter_reg <= AREA_BITS'(a_ow_reg) * AREA_BITS'(a_oh_reg);
            b_a1_reg    <= AREA_BITS'(a_w1_reg) * AREA_BITS'(a_h1_reg);
            b_a2_reg    <= AREA_BITS'(a_w2_reg) * AREA_BITS'(a_h2_reg);
        end
        if (c_rdy) begin
            c_item_reg <= c_item_next;
        end
    end

    assign out_valid = c_vld_reg;
    assign out_item  = c_item_reg;

endmodule

// ===== design/bor_div.sv =====
module bor_div (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           in_valid,
    output logic           in_ready,
    input  bor_pkg::area_t in_item,
    output logic           out_valid,
    input  logic           out_ready,
    output bor_pkg::out_t  out_item
);
    import bor_pkg::*;

    // One restoring-division step per stage, quotient MSB first.
    logic                  vld_reg  [DIV_STAGES];
    logic                  ovl_reg  [DIV_STAGES];
    logic [REM_BITS-1:0]   rem_reg  [DIV_STAGES];
    logic [UNI_BITS-1:0]   uni_reg  [DIV_STAGES];
    logic [RATIO_BITS-1:0] quot_reg [DIV_STAGES];

    logic [REM_BITS-1:0]   src_rem   [DIV_STAGES];
    logic [UNI_BITS-1:0]   src_uni   [DIV_STAGES];
    logic [RATIO_BITS-1:0] src_quot  [DIV_STAGES];
    logic                  src_ovl   [DIV_STAGES];
    logic                  src_vld   [DIV_STAGES];
    logic                  ge        [DIV_STAGES];
    logic [REM_BITS-1:0]   rem_next  [DIV_STAGES];
    logic [RATIO_BITS-1:0] quot_next [DIV_STAGES];
    logic                  rdy       [DIV_STAGES+1];

    always_comb begin
        src_rem[0]  = REM_BITS'(in_item.inter);
        src_uni[0]  = in_item.uni;
        src_quot[0] = '0;
        src_ovl[0]  = in_item.overlaps;
        src_vld[0]  = in_valid;
        for (int i = 1; i < DIV_STAGES; i++) begin
            // remainder stays below the divisor, so the shift never overflows
            src_rem[i]  = {rem_reg[i-1][REM_BITS-2:0], 1'b0};
            src_uni[i]  = uni_reg[i-1];
            src_quot[i] = quot_reg[i-1];
            src_ovl[i]  = ovl_reg[i-1];
            src_vld[i]  = vld_reg[i-1];
        end
        for (int i = 0; i < DIV_STAGES; i++) begin
            ge[i]        = src_rem[i] >= REM_BITS'(src_uni[i]);
            rem_next[i]  = ge[i] ? (src_rem[i] - REM_BITS'(src_uni[i])) : src_rem[i];
            quot_next[i] = {src_quot[i][RATIO_BITS-2:0], ge[i]};
        end
        rdy[DIV_STAGES] = out_ready;
        for (int i = DIV_STAGES - 1; i >= 0; i--) begin
            rdy[i] = !vld_reg[i] || rdy[i+1];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < DIV_STAGES; i++) begin
                vld_reg[i] <= 1'b0;
            end
        end else begin
            for (int i = 0; i < DIV_STAGES; i++) begin
                if (rdy[i]) vld_reg[i] <= src_vld[i];
            end
        end
    end

    always_ff @(posedge aclk) begin
        for (int i = 0; i < DIV_STAGES; i++) begin
            if (rdy[i]) begin
                ovl_reg[i]  <= src_ovl[i];
                rem_reg[i]  <= rem_next[i];
                uni_reg[i]  <= src_uni[i];
                quot_reg[i] <= quot_next[i];
            end
        end
    end

    assign in_ready           = rdy[0];
    assign out_valid          = vld_reg[DIV_STAGES-1];
    assign out_item.ratio_q16 = quot_reg[DIV_STAGES-1];
    assign out_item.overlaps  = ovl_reg[DIV_STAGES-1];

endmodule

// ===== design/box_overlap_ratio_top.sv =====
// Intersection over union of two axis-aligned rectangles. Each input item
// carries two rectangles as left/top/width/height (12-bit unsigned); each
// result item gives the overlap area over the union area as unsigned Q0.16,
// truncated toward zero (65536 = identical boxes), plus an overlaps flag.
// Boxes that only touch, miss each other or have zero size give ratio 0 and
// overlaps 0. The block is a 20-stage pipeline: three stages for the overlap
// extents, the three area multipliers and the union sum, then a 17-stage
// restoring divider that resolves one quotient bit per stage. It takes one
// item per cycle while the output is not stalled. Each stage holds its item
// until the next stage frees up, so back-pressure fills bubbles first and
// only then reaches s_ready; no item is lost or repeated.
module box_overlap_ratio_top (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    input  bor_pkg::in_t  s_item,
    output logic          m_valid,
    input  logic          m_ready,
    output bor_pkg::out_t m_item
);
    import bor_pkg::*;

    logic  area_valid;
    logic  area_ready;
    area_t area_item;

    // overlap extents, areas and union
    bor_area u_area (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .in_item   (s_item),
        .out_valid (area_valid),
        .out_ready (area_ready),
        .out_item  (area_item)
    );

    // inter * 2^16 / union, last stage drives the result port directly
    bor_div u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (area_valid),
        .in_ready  (area_ready),
        .in_item   (area_item),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .out_item  (m_item)
    );

endmodule

// ===== design/bor_checker.sv =====
module bor_checker (
    input logic          aclk,
    input logic          aresetn,
    input logic          s_valid,
    input logic          s_ready,
    input logic          m_valid,
    input logic          m_ready,
    input bor_pkg::out_t m_item
);
    import bor_pkg::*;

    localparam logic [RATIO_BITS-1:0] RATIO_ONE = RATIO_BITS'(1) << FRAC_BITS;

    logic s_seen;
    assign s_seen = s_valid && s_ready;

    // stalled result holds
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_item))
        else $error("result changed while stalled");

    // ratio never exceeds one
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_item.ratio_q16 <= RATIO_ONE)
        else $error("ratio above one");

    // no overlap means zero ratio
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_item.overlaps |-> m_item.ratio_q16 == '0)
        else $error("nonzero ratio without overlap");

    // pipeline empty right after reset
    assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // nothing can come out in the cycle after an idle reset release
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(aresetn) && !s_seen |=> !m_valid)
        else $error("result without accepted item");

endmodule

bind box_overlap_ratio_top bor_checker u_bor_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_item  (m_item)
);
